[sv/sca_pkg.sv]
package sca_pkg;

  localparam int unsigned SCA_CHANNELS = 8;
  localparam int unsigned SCA_IDX_W    = 6;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STOP  = 1'b1;

  localparam logic [3:0] SLOT_ANY  = 4'hf;
  localparam logic [3:0] SLOT_NONE = 4'h0;

  localparam logic signed [31:0] LIFE_MAX = 32'sh7fffffff;

  localparam logic [31:0] PLAYER_RESET = 32'd1;

  typedef struct packed {
    logic        op;
    logic [31:0] entity;
    logic [3:0]  slot;
    logic [30:0] now;
    logic [31:0] player;
  } sca_req_t;

  typedef struct packed {
    logic                 valid;
    logic                 done;
    logic                 found;
    logic signed [31:0]   best;
    logic [SCA_IDX_W-1:0] pick;
  } sca_tok_t;

  typedef struct packed {
    logic                 we;
    logic [SCA_IDX_W-1:0] idx;
    logic [31:0]          entity;
    logic [3:0]           slot;
    logic                 active;
    logic [31:0]          end_time;
  } sca_wr_t;

endpackage

[sv/sca_req_if.sv]
interface sca_req_if;
  logic              valid;
  logic              ready;
  logic              op;
  logic [31:0]       entity;
  logic signed [3:0] entity_slot;
  logic [8:0]        sound_id;
  logic [23:0]       sound_length;
  logic [30:0]       now;
  logic              playable;

  modport source (
    output valid, op, entity, entity_slot, sound_id, sound_length, now, playable,
    input  ready
  );

  modport sink (
    input  valid, op, entity, entity_slot, sound_id, sound_length, now, playable,
    output ready
  );
endinterface

[sv/sca_rsp_if.sv]
interface sca_rsp_if;
  logic       valid;
  logic       ready;
  logic       found;
  logic [5:0] channel_index;
  logic       started;

  modport source (
    output valid, found, channel_index, started,
    input  ready
  );

  modport sink (
    input  valid, found, channel_index, started,
    output ready
  );
endinterface

[sv/sca_cell.sv]
module sca_cell
  import sca_pkg::*;
#(
  parameter int unsigned IDX = 0
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  sca_req_t req_i,
  input  sca_wr_t  wr_i,
  input  sca_tok_t tok_i,
  output sca_tok_t tok_o
);

  localparam logic [SCA_IDX_W-1:0] MyIdx = SCA_IDX_W'(IDX);

  logic [31:0]        owner_q;
  logic [3:0]         slot_q;
  logic               active_q;
  logic [31:0]        end_q;
  sca_tok_t           tok_q, tok_d;

  logic               own_match;
  logic               stop_hit;
  logic               exact_hit;
  logic               guarded;
  logic signed [31:0] life;
  logic               live;
  logic               stop_clr;

  assign own_match = (owner_q == req_i.entity);
  assign stop_hit  = own_match && (slot_q == req_i.slot);
  assign exact_hit = (req_i.slot != SLOT_NONE) && own_match &&
                     ((slot_q == req_i.slot) || (req_i.slot == SLOT_ANY));
  assign guarded   = (owner_q == req_i.player) && (req_i.entity != req_i.player) && active_q;
  assign life      = $signed(end_q - {1'b0, req_i.now});
  assign live      = tok_i.valid && !tok_i.done;

  always_comb begin
    tok_d    = tok_i;
    stop_clr = 1'b0;
    if (live) begin
      if (req_i.op == OP_STOP) begin
        if (stop_hit) begin
          tok_d.done  = 1'b1;
          tok_d.found = 1'b1;
          tok_d.pick  = MyIdx;
          stop_clr    = 1'b1;
        end
      end else if (exact_hit) begin
        tok_d.done  = 1'b1;
        tok_d.found = 1'b1;
        tok_d.pick  = MyIdx;
      end else if (!guarded && (life < tok_i.best)) begin
        tok_d.best  = life;
        tok_d.found = 1'b1;
        tok_d.pick  = MyIdx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q    <= '0;
      owner_q  <= '0;
      slot_q   <= '0;
      active_q <= 1'b0;
      end_q    <= '0;
    end else begin
      tok_q <= tok_d;
      if (wr_i.we && (wr_i.idx == MyIdx)) begin
        owner_q  <= wr_i.entity;
        slot_q   <= wr_i.slot;
        active_q <= wr_i.active;
        end_q    <= wr_i.end_time;
      end else if (stop_clr) begin
        active_q <= 1'b0;
        end_q    <= '0;
      end
    end
  end

  assign tok_o = tok_q;

endmodule

[sv/sound_channel_stealing_allocator_top.sv]
// Sound channel allocator with voice stealing over CHANNELS dynamic channels.
// One request (start or stop) is handled at a time: a scan token walks the row
// of channel cells, one cell per clock, and the result is registered before it
// is offered. The next request is taken once the scan is done and the previous
// result has left or leaves in that cycle.
// A start first reuses a channel of the same entity and slot, else steals the
// channel with least remaining life; active channels of player_entity are kept
// unless the player asks. Write player_entity only while no request is open.
module sound_channel_stealing_allocator_top
  import sca_pkg::*;
#(
  parameter int unsigned CHANNELS = SCA_CHANNELS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sca_req_if.sink     req_i,
  sca_rsp_if.source   rsp_o,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_data_i
);

  logic [31:0] player_q;
  logic        busy_q;
  logic        inj_q;
  logic        op_q;
  logic [31:0] entity_q;
  logic [3:0]  slot_q;
  logic [30:0] now_q;
  logic [23:0] len_q;
  logic        play_q;

  logic        out_valid_q;
  logic        out_found_q;
  logic [5:0]  out_idx_q;
  logic        out_started_q;

  logic        accept;
  sca_req_t    req;
  sca_wr_t     wr;
  sca_tok_t    tok [CHANNELS+1];
  sca_tok_t    tail;

  assign req_i.ready = !busy_q && (!out_valid_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;

  assign req.op     = op_q;
  assign req.entity = entity_q;
  assign req.slot   = slot_q;
  assign req.now    = now_q;
  assign req.player = player_q;

  assign tok[0].valid = inj_q;
  assign tok[0].done  = 1'b0;
  assign tok[0].found = 1'b0;
  assign tok[0].best  = LIFE_MAX;
  assign tok[0].pick  = '0;

  for (genvar g = 0; g < CHANNELS; g++) begin : g_cell
    sca_cell #(
      .IDX (g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .req_i  (req),
      .wr_i   (wr),
      .tok_i  (tok[g]),
      .tok_o  (tok[g+1])
    );
  end

  assign tail = tok[CHANNELS];

  assign wr.we       = tail.valid && (op_q == OP_START) && tail.found;
  assign wr.idx      = tail.pick;
  assign wr.entity   = entity_q;
  assign wr.slot     = slot_q;
  assign wr.active   = play_q;
  assign wr.end_time = play_q ? ({1'b0, now_q} + {8'd0, len_q}) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      player_q    <= PLAYER_RESET;
      busy_q      <= 1'b0;
      inj_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        player_q <= cfg_data_i;
      end
      inj_q <= accept;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (tail.valid) begin
        busy_q <= 1'b0;
      end
      if (tail.valid) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= req_i.op;
      entity_q <= req_i.entity;
      slot_q   <= req_i.entity_slot;
      now_q    <= req_i.now;
      len_q    <= req_i.sound_length;
      play_q   <= req_i.playable;
    end
    if (tail.valid) begin
      out_found_q   <= tail.found;
      out_idx_q     <= tail.pick;
      out_started_q <= (op_q == OP_START) && tail.found && play_q;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.found         = out_found_q;
  assign rsp_o.channel_index = out_idx_q;
  assign rsp_o.started       = out_started_q;

endmodule
